>>> rtl/lstu_pkg.sv
// Package: shared types and constants of the list intersection block.
package lstu_pkg;

    localparam int MaxFound = 32;
    localparam int FoundAw  = 5;
    localparam int FoundCw  = 6;

    localparam logic [1:0] FuncLoadA = 2'd0;
    localparam logic [1:0] FuncLoadB = 2'd1;
    localparam logic [1:0] FuncRun   = 2'd2;

    typedef struct packed {
        logic        [1:0]  func;
        logic signed [31:0] value;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0]        common_value;
        logic                      has_value;
        logic [FoundAw-1:0]        position;
        logic [FoundCw-1:0]        found_count;
        logic                      last_result;
        logic                      dropped;
    } t_out_item;

endpackage

>>> rtl/lstu_if.sv
// Interfaces: valid/ready channels for input and result items.
interface lstu_in_if;
    logic               valid;
    logic               ready;
    lstu_pkg::t_in_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface lstu_out_if;
    logic                valid;
    logic                ready;
    lstu_pkg::t_out_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

>>> rtl/lstu_out_stage.sv
// Output register: holds one result item until the sink takes it.
module lstu_out_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  lstu_pkg::t_out_item i_item,
    output logic                o_free,
    lstu_out_if.source          o_out
);

    logic                r_valid;
    lstu_pkg::t_out_item r_item;

    assign o_free        = !r_valid || o_out.ready;
    assign o_out.valid   = r_valid;
    assign o_out.payload = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_item <= i_item;
        end
    end

endmodule

>>> rtl/list_intersection_unique.sv
// Load item: taken in the idle state. Run item: each first-list element is scanned serially
// against the second list and then the found store, bounded by the one-port memories.
// Results then leave one at a time through the output register (empty result: one item).
// Input is stalled from run acceptance until the last result is in the output register.
// Reset (synchronous, active low) clears counts, drop flag, sequencer and output valid;
// list memories are not cleared.
module list_intersection_unique #(
    parameter int LIST_DEPTH = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lstu_in_if.sink    i_in,
    lstu_out_if.source o_out
);

    localparam int CntW  = $clog2(LIST_DEPTH + 1);
    localparam int AddrW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int ScanW = (CntW > lstu_pkg::FoundCw) ? CntW : lstu_pkg::FoundCw;

    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_FETCH   = 7'b0000010,
        S_GETX    = 7'b0000100,
        S_SCANB   = 7'b0001000,
        S_SCANF   = 7'b0010000,
        S_EMIT_RD = 7'b0100000,
        S_EMIT_LD = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    logic [CntW-1:0]              r_first_count, n_first_count;
    logic [CntW-1:0]              r_second_count, n_second_count;
    logic                         r_ovf, n_ovf;
    logic                         r_drop, n_drop;
    logic [CntW-1:0]              r_i, n_i;
    logic [ScanW-1:0]             r_cnt, n_cnt;
    logic                         r_pend, n_pend;
    logic [lstu_pkg::FoundCw-1:0] r_n, n_n;
    logic [lstu_pkg::FoundCw-1:0] r_k, n_k;
    logic [31:0]                  r_x, n_x;

    // list and found stores, registered reads
    logic [31:0] r_mem_a [LIST_DEPTH];
    logic [31:0] r_mem_b [LIST_DEPTH];
    logic [31:0] r_mem_f [lstu_pkg::MaxFound];
    logic [31:0] r_a_q, r_b_q, r_f_q;

    logic                         a_we, b_we, f_we;
    logic [lstu_pkg::FoundAw-1:0] f_raddr;
    logic                         in_acc;
    logic [31:0]                  scan_q;
    logic [ScanW-1:0]             scan_lim;
    logic                         scan_hit, scan_more;
    logic                         fetch_go;
    logic                         out_free, out_load;
    lstu_pkg::t_out_item          out_item;

    assign i_in.ready = (r_state == S_IDLE);
    assign in_acc     = i_in.valid && i_in.ready;

    assign scan_q    = (r_state == S_SCANB) ? r_b_q : r_f_q;
    assign scan_lim  = (r_state == S_SCANB) ? ScanW'(r_second_count) : ScanW'(r_n);
    assign scan_hit  = r_pend && (scan_q == r_x);
    assign scan_more = (r_cnt < scan_lim);
    assign fetch_go  = (r_i < r_first_count) && (r_n < lstu_pkg::FoundCw'(lstu_pkg::MaxFound));
    assign f_raddr   = (r_state == S_SCANF) ? r_cnt[lstu_pkg::FoundAw-1:0]
                                            : r_k[lstu_pkg::FoundAw-1:0];

    always_ff @(posedge i_clk) begin
        if (a_we) begin
            r_mem_a[r_first_count[AddrW-1:0]] <= i_in.payload.value;
        end
        r_a_q <= r_mem_a[r_i[AddrW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (b_we) begin
            r_mem_b[r_second_count[AddrW-1:0]] <= i_in.payload.value;
        end
        r_b_q <= r_mem_b[r_cnt[AddrW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (f_we) begin
            r_mem_f[r_n[lstu_pkg::FoundAw-1:0]] <= r_x;
        end
        r_f_q <= r_mem_f[f_raddr];
    end

    always_comb begin
        n_state        = r_state;
        n_first_count  = r_first_count;
        n_second_count = r_second_count;
        n_ovf          = r_ovf;
        n_drop         = r_drop;
        n_i            = r_i;
        n_cnt          = r_cnt;
        n_pend         = r_pend;
        n_n            = r_n;
        n_k            = r_k;
        n_x            = r_x;
        a_we           = 1'b0;
        b_we           = 1'b0;
        f_we           = 1'b0;
        out_load       = 1'b0;

        out_item              = '0;
        out_item.dropped      = r_drop;
        out_item.last_result  = 1'b1;
        if (r_n != '0) begin
            out_item.common_value = r_f_q;
            out_item.has_value    = 1'b1;
            out_item.position     = r_k[lstu_pkg::FoundAw-1:0];
            out_item.found_count  = r_n;
            out_item.last_result  = ((r_k + 1'b1) == r_n);
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    unique case (i_in.payload.func)
                        lstu_pkg::FuncLoadA: begin
                            if (r_first_count < CntW'(LIST_DEPTH)) begin
                                a_we          = 1'b1;
                                n_first_count = r_first_count + 1'b1;
                            end else begin
                                n_ovf = 1'b1;
                            end
                        end
                        lstu_pkg::FuncLoadB: begin
                            if (r_second_count < CntW'(LIST_DEPTH)) begin
                                b_we           = 1'b1;
                                n_second_count = r_second_count + 1'b1;
                            end else begin
                                n_ovf = 1'b1;
                            end
                        end
                        lstu_pkg::FuncRun: begin
                            n_i     = '0;
                            n_n     = '0;
                            n_state = S_FETCH;
                        end
                        default: ;
                    endcase
                end
            end
            S_FETCH: begin
                if (fetch_go) begin
                    n_state = S_GETX;
                end else begin
                    n_drop         = r_ovf;
                    n_ovf          = 1'b0;
                    n_first_count  = '0;
                    n_second_count = '0;
                    n_k            = '0;
                    n_state        = (r_n == '0) ? S_EMIT_LD : S_EMIT_RD;
                end
            end
            S_GETX: begin
                n_x     = r_a_q;
                n_cnt   = '0;
                n_pend  = 1'b0;
                n_state = S_SCANB;
            end
            S_SCANB: begin
                // hit seen in the cycle after its address went out
                if (scan_hit) begin
                    n_cnt   = '0;
                    n_pend  = 1'b0;
                    n_state = S_SCANF;
                end else if (scan_more) begin
                    n_cnt  = r_cnt + 1'b1;
                    n_pend = 1'b1;
                end else begin
                    n_i     = r_i + 1'b1;
                    n_state = S_FETCH;
                end
            end
            S_SCANF: begin
                if (scan_hit) begin
                    n_i     = r_i + 1'b1;
                    n_state = S_FETCH;
                end else if (scan_more) begin
                    n_cnt  = r_cnt + 1'b1;
                    n_pend = 1'b1;
                end else begin
                    f_we    = 1'b1;
                    n_n     = r_n + 1'b1;
                    n_i     = r_i + 1'b1;
                    n_state = S_FETCH;
                end
            end
            S_EMIT_RD: begin
                n_state = S_EMIT_LD;
            end
            S_EMIT_LD: begin
                if (out_free) begin
                    out_load = 1'b1;
                    if (out_item.last_result) begin
                        n_state = S_IDLE;
                    end else begin
                        n_k     = r_k + 1'b1;
                        n_state = S_EMIT_RD;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_first_count  <= '0;
            r_second_count <= '0;
            r_ovf          <= 1'b0;
            r_drop         <= 1'b0;
            r_i            <= '0;
            r_cnt          <= '0;
            r_pend         <= 1'b0;
            r_n            <= '0;
            r_k            <= '0;
        end else begin
            r_state        <= n_state;
            r_first_count  <= n_first_count;
            r_second_count <= n_second_count;
            r_ovf          <= n_ovf;
            r_drop         <= n_drop;
            r_i            <= n_i;
            r_cnt          <= n_cnt;
            r_pend         <= n_pend;
            r_n            <= n_n;
            r_k            <= n_k;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x <= n_x;
    end

    lstu_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (out_load),
        .i_item  (out_item),
        .o_free  (out_free),
        .o_out   (o_out)
    );

`ifndef SYNTHESIS
    a_found_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= lstu_pkg::FoundCw'(lstu_pkg::MaxFound))
        else $error("found count beyond capacity");

    a_found_write_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        f_we |-> (r_n < lstu_pkg::FoundCw'(lstu_pkg::MaxFound)))
        else $error("found store written when full");

    a_run_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FETCH && !fetch_go) |=>
            (r_first_count == '0 && r_second_count == '0 && !r_ovf))
        else $error("lists not cleared after run");

    a_empty_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && !out_item.has_value) |->
            (out_item.last_result && out_item.found_count == '0))
        else $error("malformed empty result");

    a_no_input_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !(a_we || b_we))
        else $error("list written during run");
`endif

endmodule
